/* sv/pts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg: shared types and codes for the priority task scheduler
// Word formats, action and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_RUN  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOALLOC = 2'd2;

  localparam logic [7:0] PRIO_LOWEST = 8'd255;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] priority_req;
    logic [3:0] task_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  assigned_id;
    logic [3:0]  active_id;
    logic [31:0] tick_count;
  } out_word_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic rd;
    logic load_out;
  } pts_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic cnt_one;
    logic scan_last;
    logic out_free;
  } pts_sts_t;

endpackage

/* sv/pts_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ctrl: scheduler sequencer
// Takes one word at a time, runs the table scan on ticks, hands off results.
// ----------------------------------------------------------------------------
module pts_ctrl
  import pts_pkg::*;
#(
  parameter int IDW = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pts_sts_t       sts,
  output pts_cmd_t       cmd,
  output logic [IDW-1:0] scan_addr
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t         state_r;
  state_t         state_nxt;
  logic [IDW-1:0] scan_idx_r;
  logic [IDW-1:0] scan_idx_nxt;

  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_tick && !sts.cnt_one) begin
          state_nxt    = S_SCAN;
          scan_idx_nxt = IDW'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + IDW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.load_out = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign scan_addr = scan_idx_r;

endmodule

/* sv/pts_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_dpath: scheduler datapath
// Task table, ready marks, tick counter, scan compare and result register.
// ----------------------------------------------------------------------------
module pts_dpath
  import pts_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int IDW       = 4,
  parameter int CW        = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  in_word_t       in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output out_word_t      out_data,
  input  pts_cmd_t       cmd,
  input  logic [IDW-1:0] scan_addr,
  output pts_sts_t       sts
);

  localparam int CMPW = (CW > 4) ? CW : 4;
  localparam int XW   = (IDW > 4) ? IDW : 4;

  in_word_t       item_r;
  logic [7:0]     prio_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] ready_r;
  logic [CW-1:0]  count_r;
  logic [IDW-1:0] active_r;
  logic [31:0]    ticks_r;

  logic [7:0]     rd_prio_r;
  logic           rd_rdy_r;
  logic [IDW-1:0] rd_idx_r;
  logic           rd_vld_r;
  logic [IDW-1:0] best_r;
  logic [7:0]     best_prio_r;

  logic [1:0]     res_status_r;
  logic [3:0]     res_assigned_r;
  logic           out_valid_r;
  out_word_t      out_word_r;

  logic            is_full;
  logic [CMPW-1:0] tid_ext;
  logic            tid_bad;
  logic            add_ok;
  logic [IDW-1:0]  new_idx;
  logic [IDW-1:0]  tid_idx;
  logic [CMPW-1:0] cnt_ext;
  logic [XW-1:0]   active_sel;
  logic [XW-1:0]   best_ext;

  assign is_full = (count_r >= CW'(MAX_TASKS));
  assign tid_ext = CMPW'(item_r.task_id);
  assign cnt_ext = CMPW'(count_r);
  assign tid_bad = (tid_ext >= cnt_ext);
  assign tid_idx = IDW'(tid_ext);
  assign new_idx = IDW'(count_r);
  assign add_ok  = cmd.exec && (item_r.action == ACT_ADD) && !is_full;

  assign sts.is_tick   = (item_r.action == ACT_TICK);
  assign sts.cnt_one   = (count_r == CW'(1));
  assign sts.scan_last = ((CW'(scan_addr) + CW'(1)) == count_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (add_ok) begin
      prio_mem[new_idx] <= item_r.priority_req;
    end
    if (cmd.rd) begin
      rd_prio_r <= prio_mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.rd) begin
      rd_rdy_r <= ready_r[scan_addr];
      rd_idx_r <= scan_addr;
    end
    if (cmd.exec) begin
      res_status_r   <= ST_OK;
      res_assigned_r <= 4'd0;
      case (item_r.action)
        ACT_ADD: begin
          if (is_full) begin
            res_status_r <= ST_FULL;
          end else begin
            res_assigned_r <= cnt_ext[3:0];
          end
        end
        ACT_RUN: begin
          if (tid_bad) begin
            res_status_r <= ST_NOALLOC;
          end
        end
        default: begin
        end
      endcase
      best_r      <= '0;
      best_prio_r <= PRIO_LOWEST;
    end else if (rd_vld_r && rd_rdy_r && (rd_prio_r < best_prio_r)) begin
      best_r      <= rd_idx_r;
      best_prio_r <= rd_prio_r;
    end
  end

  assign best_ext   = XW'(best_r);
  assign active_sel = XW'(active_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r.status      <= res_status_r;
      out_word_r.assigned_id <= res_assigned_r;
      out_word_r.active_id   <= (item_r.action == ACT_TICK) ? best_ext[3:0]
                                                            : active_sel[3:0];
      out_word_r.tick_count  <= ticks_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r     <= '0;
      count_r     <= CW'(1);
      active_r    <= '0;
      ticks_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (add_ok) begin
        ready_r[new_idx] <= 1'b0;
        count_r          <= count_r + CW'(1);
      end
      if (cmd.exec && (item_r.action == ACT_RUN) && !tid_bad) begin
        ready_r[tid_idx] <= 1'b1;
      end
      if (cmd.exec && (item_r.action == ACT_TICK)) begin
        ticks_r <= ticks_r + 32'd1;
      end
      if (cmd.load_out && (item_r.action == ACT_TICK)) begin
        active_r <= best_r;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

/* sv/priority_task_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler: fixed-priority task table and dispatch decision
// Usage:
//   Input words (in_valid/in_stall/in_data) carry an action: add a task with
//   a priority, mark a task ready, or tick. Each word yields exactly one
//   output word (out_valid/out_stall/out_data) with status, the task number
//   given by an add, the selected task and the tick count.
//   Add, run and unused actions need no scan. A tick scans the table one
//   entry per cycle through the priority memory read port, unless the idle
//   task is the only one allocated. One word is in work at a time; the next
//   word is taken the cycle after its result is loaded, even while that
//   result is stalled.
//   Reset leaves only the idle task (entry 0, priority 255), no ready marks,
//   task 0 selected and the tick count at zero.
//   A stalled output word holds; a finished result waits in the sequencer
//   until the output register is free, with in_stall high meanwhile.
// ----------------------------------------------------------------------------
module priority_task_scheduler
  import pts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int IDW = $clog2(MAX_TASKS);
  localparam int CW  = $clog2(MAX_TASKS + 1);

  pts_cmd_t       cmd;
  pts_sts_t       sts;
  logic [IDW-1:0] scan_addr;

  pts_ctrl #(
    .IDW(IDW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .scan_addr(scan_addr)
  );

  pts_dpath #(
    .MAX_TASKS(MAX_TASKS),
    .IDW      (IDW),
    .CW       (CW)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cmd      (cmd),
    .scan_addr(scan_addr),
    .sts      (sts)
  );

endmodule

/* sv/pts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_checker: port-level checks for the priority task scheduler
// Watches handshakes and result words; attached by bind.
// ----------------------------------------------------------------------------
module pts_checker
  import pts_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FULL ||
                   out_data.status == ST_NOALLOC))
    else $error("unknown status code");

  a_assigned_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> (out_data.assigned_id == 4'd0))
    else $error("task number given on a failed word");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

/* sim/pts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_scoreboard: result predictor and scoreboard for the priority task scheduler
// Watches both channels. Every accepted input word is run through a local
// copy of the task table, the tick counter and the dispatch choice. The
// predicted result word is queued, and each accepted output word is checked
// field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module pts_scoreboard
  import pts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        mismatches,
  output int        outstanding
);

  logic [7:0]  prio_tbl  [MAX_TASKS];
  logic        ready_tbl [MAX_TASKS];
  int          task_total;
  int          running_task;
  logic [31:0] tick_ctr;
  out_word_t   dispatch_q [$];
  int          err_count;

  function automatic out_word_t schedule_word(input in_word_t w);
    out_word_t r;
    int        best;
    r.status      = ST_OK;
    r.assigned_id = '0;
    case (w.action)
      ACT_ADD: begin
        if (task_total >= MAX_TASKS) begin
          r.status = ST_FULL;
        end else begin
          prio_tbl[task_total]  = w.priority_req;
          ready_tbl[task_total] = 1'b0;
          r.assigned_id         = task_total[3:0];
          task_total++;
        end
      end
      ACT_RUN: begin
        if (int'(w.task_id) >= task_total) begin
          r.status = ST_NOALLOC;
        end else begin
          ready_tbl[w.task_id] = 1'b1;
        end
      end
      ACT_TICK: begin
        tick_ctr++;
        best = 0;
        // strict compare keeps the lower index on equal priority
        for (int i = 0; i < task_total; i++) begin
          if (ready_tbl[i] && prio_tbl[i] < prio_tbl[best]) best = i;
        end
        running_task = best;
      end
      default: ;
    endcase
    r.active_id  = running_task[3:0];
    r.tick_count = tick_ctr;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  initial begin
    err_count   = 0;
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        prio_tbl[i]  = '0;
        ready_tbl[i] = 1'b0;
      end
      prio_tbl[0]  = PRIO_LOWEST;
      task_total   = 1;
      running_task = 0;
      tick_ctr     = '0;
      dispatch_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (dispatch_q.size() == 0) begin
          $error("result word %h with no input word pending", out_data);
          err_count++;
        end else begin
          want = dispatch_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("assigned_id", 32'(want.assigned_id), 32'(out_data.assigned_id));
          check_field("active_id", 32'(want.active_id), 32'(out_data.active_id));
          check_field("tick_count", want.tick_count, out_data.tick_count);
        end
      end
      if (in_valid && !in_stall) dispatch_q.push_back(schedule_word(in_data));
    end
    mismatches  <= err_count;
    outstanding <= dispatch_q.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the priority task scheduler
// A short directed sequence walks through the dispatch corner cases, then
// random action words fill the table and exercise ready marks and ticks
// under three handshake regimes: dense input with heavy output stall,
// the reverse, and full rate. The scoreboard instance checks each result word.
// ----------------------------------------------------------------------------
module testbench;
  import pts_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int PHASE_WORDS    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  int send_gap_pct;
  int recv_stall_pct = 0;
  int idle_cycles;
  int mismatches;
  int outstanding;

  always #5 clk = ~clk;

  priority_task_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  pts_scoreboard u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** priority_task_scheduler: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_word_t make_word(input logic [1:0] act, input logic [7:0] prio,
                                         input logic [3:0] id);
    in_word_t w;
    w.action       = act;
    w.priority_req = prio;
    w.task_id      = id;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick           = $urandom_range(99);
    w.task_id      = 4'($urandom_range(15));
    w.priority_req = 8'($urandom_range(255));
    // small and extreme priorities make ties and idle fallbacks common
    case ($urandom_range(3))
      0: w.priority_req = $urandom_range(1) ? 8'd255 : 8'd0;
      1: w.priority_req = 8'($urandom_range(3));
      default: ;
    endcase
    if (pick < 20)      w.action = ACT_ADD;
    else if (pick < 55) w.action = ACT_RUN;
    else if (pick < 92) w.action = ACT_TICK;
    else                w.action = ACT_NONE;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    send_gap_pct = 15;
    recv_stall_pct <= 63;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(make_word(ACT_TICK, 8'd0, 4'd0));     // idle only
    send_word(make_word(ACT_RUN, 8'd0, 4'd0));      // ready idle task
    send_word(make_word(ACT_TICK, 8'd255, 4'd15));
    send_word(make_word(ACT_RUN, 8'd0, 4'd15));     // unallocated
    send_word(make_word(ACT_RUN, 8'd255, 4'd1));
    send_word(make_word(ACT_NONE, 8'd255, 4'd15));
    send_word(make_word(ACT_ADD, 8'd255, 4'd15));   // task 1, lowest priority
    send_word(make_word(ACT_RUN, 8'd0, 4'd1));
    send_word(make_word(ACT_TICK, 8'd0, 4'd0));     // 255 loses to idle
    send_word(make_word(ACT_ADD, 8'd0, 4'd0));      // task 2
    send_word(make_word(ACT_TICK, 8'd0, 4'd0));     // not ready yet
    send_word(make_word(ACT_RUN, 8'd0, 4'd2));
    send_word(make_word(ACT_TICK, 8'd0, 4'd0));
    send_word(make_word(ACT_ADD, 8'd0, 4'd0));      // task 3, same priority
    send_word(make_word(ACT_RUN, 8'd0, 4'd3));
    send_word(make_word(ACT_TICK, 8'd0, 4'd0));     // tie keeps task 2
    send_word(make_word(ACT_ADD, 8'd170, 4'd5));
    send_word(make_word(ACT_ADD, 8'd85, 4'd10));
    send_word(make_word(ACT_RUN, 8'd0, 4'd5));
    send_word(make_word(ACT_RUN, 8'd0, 4'd6));      // one past the end
    send_word(make_word(ACT_TICK, 8'd0, 4'd0));
    send_word(make_word(ACT_NONE, 8'd0, 4'd0));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_gap_pct = 15; recv_stall_pct <= 63; end
        1: begin send_gap_pct = 63; recv_stall_pct <= 15; end
        default: begin send_gap_pct = 0; recv_stall_pct <= 0; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word());
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** priority_task_scheduler: PASSED **");
    end else begin
      $display("** priority_task_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
